// ===== design/art_pkg.sv =====
// Shared types, constants and codes of the access rule table.
`timescale 1ns / 1ps

package art_pkg;

    // Default sizing of the rule store
    localparam int RULE_SLOTS_DEF = 64;
    localparam int ID_BITS_DEF    = 16;

    // Fixed field widths on the stream ports
    localparam int FIELD_ID_W = 16;
    localparam int PERM_W     = 32;
    localparam int IN_DATA_W  = 3 * FIELD_ID_W + PERM_W;
    localparam int OUT_DATA_W = 8;

    // Item kind carried in tuser
    typedef enum logic {
        MODE_ADD   = 1'b0,
        MODE_CHECK = 1'b1
    } t_mode;

    // Result status codes
    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // One result item
    typedef struct packed {
        t_status status;
        logic    granted;
    } t_result;

endpackage

// ===== design/access_rule_table_top.sv =====
// Top level of the access rule table: stream ports, key packing, result register.
// An add, or a check of an empty table, goes straight to the done state; a
// check scans the stored rules from slot zero and stops at the first match or the
// last stored rule. Items are handled one at a time; the next item is taken once
// the result enters the output register, and a check scans the rule memory one
// entry per cycle. Reset is synchronous: it empties the table by clearing the
// fill count, with no clearing pass over the memory.
`timescale 1ns / 1ps

module access_rule_table_top #(
    parameter int RULE_SLOTS = art_pkg::RULE_SLOTS_DEF,
    parameter int ID_BITS    = art_pkg::ID_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // source_type[15:0], target_type[31:16], object_class[47:32], permission_bits[79:48]
    input  logic [art_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // granted[0], status[1], zero[7:2]
    output logic [art_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import art_pkg::*;

    localparam int KEY_W  = 3 * ID_BITS;
    localparam int WORD_W = KEY_W + PERM_W;
    localparam int IDX_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    logic [ID_BITS-1:0]  w_src;
    logic [ID_BITS-1:0]  w_tgt;
    logic [ID_BITS-1:0]  w_cls;
    logic [KEY_W-1:0]    w_key;
    logic [PERM_W-1:0]   w_perm;
    t_mode               w_mode;

    logic                w_res_valid;
    logic                w_res_ready;
    t_result             w_res;

    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    logic [WORD_W-1:0]   w_ram_wdata;
    logic                w_ram_re;
    logic [IDX_W-1:0]    w_ram_raddr;
    logic [WORD_W-1:0]   w_ram_rdata;

    logic                r_out_valid;
    t_result             r_out;

    // Unpack the transaction; identifiers keep their low ID_BITS bits
    assign w_src  = ID_BITS'(s_axis_tdata[FIELD_ID_W-1:0]);
    assign w_tgt  = ID_BITS'(s_axis_tdata[2*FIELD_ID_W-1:FIELD_ID_W]);
    assign w_cls  = ID_BITS'(s_axis_tdata[3*FIELD_ID_W-1:2*FIELD_ID_W]);
    assign w_perm = s_axis_tdata[IN_DATA_W-1:3*FIELD_ID_W];
    assign w_key  = {w_cls, w_tgt, w_src};
    assign w_mode = t_mode'(s_axis_tuser[0]);

    art_seq #(
        .RULE_SLOTS (RULE_SLOTS),
        .ID_BITS    (ID_BITS),
        .KEY_W      (KEY_W),
        .WORD_W     (WORD_W),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (w_mode),
        .i_key       (w_key),
        .i_perm      (w_perm),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    art_ram #(
        .DEPTH  (RULE_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Take a result when the output register is empty or drains this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    // Output register: load a result, drop it once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - 2)'(0), r_out.status, r_out.granted};

endmodule

// ===== design/art_ram.sv =====
// Single-port-write, single-port-read rule memory with registered read data.
`timescale 1ns / 1ps

module art_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 80
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/art_seq.sv =====
// Sequencer: appends rules at the fill count and scans the rule memory on checks.
`timescale 1ns / 1ps

module art_seq #(
    parameter int RULE_SLOTS = art_pkg::RULE_SLOTS_DEF,
    parameter int ID_BITS    = art_pkg::ID_BITS_DEF,
    parameter int KEY_W      = 3 * ID_BITS,
    parameter int WORD_W     = KEY_W + art_pkg::PERM_W,
    parameter int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item side
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  art_pkg::t_mode              i_mode,
    input  logic [KEY_W-1:0]            i_key,
    input  logic [art_pkg::PERM_W-1:0]  i_perm,
    // Result side
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output art_pkg::t_result            o_res,
    // Rule memory
    output logic                        o_ram_we,
    output logic [IDX_W-1:0]            o_ram_waddr,
    output logic [WORD_W-1:0]           o_ram_wdata,
    output logic                        o_ram_re,
    output logic [IDX_W-1:0]            o_ram_raddr,
    input  logic [WORD_W-1:0]           i_ram_rdata
);

    import art_pkg::*;

    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx,   n_idx;
    logic [KEY_W-1:0]    r_key,   n_key;
    logic [PERM_W-1:0]   r_bits,  n_bits;
    t_result             r_res,   n_res;

    logic                w_full;
    logic                w_empty;
    logic                w_hit;
    logic                w_last;
    logic [KEY_W-1:0]    w_rd_key;
    logic [PERM_W-1:0]   w_rd_perm;

    // Stored rules form a prefix of the memory, so the fill count marks validity
    assign w_full    = (r_count == CNT_W'(RULE_SLOTS));
    assign w_empty   = (r_count == '0);
    assign w_rd_key  = i_ram_rdata[KEY_W-1:0];
    assign w_rd_perm = i_ram_rdata[WORD_W-1:KEY_W];
    assign w_hit     = (w_rd_key == r_key);
    assign w_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_CHECK && !w_empty) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_bits      = r_bits;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[IDX_W-1:0];
        o_ram_wdata = {i_perm, i_key};
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key       = i_key;
                    n_bits      = i_perm;
                    n_idx       = '0;
                    n_res       = '{status: STATUS_OK, granted: 1'b0};
                    if (i_mode == MODE_ADD) begin
                        if (w_full) begin
                            n_res.status = STATUS_FULL;
                        end else begin
                            o_ram_we = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        // Fetch slot zero for the scan
                        o_ram_re = !w_empty;
                    end
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_res.granted = |(w_rd_perm & r_bits);
                end else if (!w_last) begin
                    // Advance to the next slot
                    n_idx       = r_idx + IDX_W'(1);
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx + IDX_W'(1);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_bits <= n_bits;
        r_res  <= n_res;
    end

    // Fill count never passes the table size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RULE_SLOTS))
        else $error("art_seq: fill count beyond table size");

    // A scan only reads slots that hold rules
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("art_seq: scan index outside stored rules");

    // Rules are written only while no scan is running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == ST_IDLE && !w_full))
        else $error("art_seq: memory write outside an add");

    // The fill count only grows, one rule at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("art_seq: fill count jumped");

    // A full table answers an add with the full status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_mode == MODE_ADD && w_full)
            |=> (r_state == ST_DONE && r_res.status == STATUS_FULL))
        else $error("art_seq: full table not reported");

endmodule

// ===== tb/tb_access_rule_table_top.sv =====
// Self-checking stream testbench for the access rule table top level.
`timescale 1ns / 1ps

module tb_access_rule_table_top;

    import art_pkg::*;

    localparam int RULE_SLOTS   = RULE_SLOTS_DEF;
    localparam int ID_BITS      = ID_BITS_DEF;
    localparam int KEY_W        = 3 * ID_BITS;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = RULE_SLOTS + 8;

    // Row marks: expectation typed in the table, or taken from the predictor
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // One request as driven on the slave side, with an optional typed expectation
    typedef struct packed {
        t_mode                 mode;
        logic [FIELD_ID_W-1:0] src;
        logic [FIELD_ID_W-1:0] tgt;
        logic [FIELD_ID_W-1:0] cls;
        logic [PERM_W-1:0]     perm;
        logic                  typed;
        logic                  exp_granted;
        t_status               exp_status;
    } t_access_req;

    localparam int DIRECTED_N = 20;

    // Directed rows: empty table, extreme keys and masks, duplicates, near misses
    localparam t_access_req DIRECTED_ROWS [DIRECTED_N] = '{
        '{MODE_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, TYPED, 1'b0, STATUS_OK},
        '{MODE_ADD,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, TYPED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, TYPED, 1'b0, STATUS_OK},
        '{MODE_ADD,   16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, TYPED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0001, TYPED, 1'b1, STATUS_OK},
        '{MODE_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, TYPED, 1'b1, STATUS_OK},
        '{MODE_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, TYPED, 1'b0, STATUS_OK},
        '{MODE_ADD,   16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, TYPED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0001, TYPED, 1'b1, STATUS_OK},
        '{MODE_ADD,   16'h1234, 16'h5678, 16'h9ABC, 32'h00FF_00FF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h1234, 16'h5678, 16'h9ABC, 32'hFF00_FF00, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h1234, 16'h5678, 16'h9ABC, 32'h0001_0000, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h1235, 16'h5678, 16'h9ABC, 32'hFFFF_FFFF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h1234, 16'h5679, 16'h9ABC, 32'hFFFF_FFFF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h1234, 16'h5678, 16'h9ABD, 32'hFFFF_FFFF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h9ABC, 16'h5678, 16'h1234, 32'hFFFF_FFFF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_ADD,   16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'h5555, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, PREDICTED, 1'b0, STATUS_OK},
        '{MODE_CHECK, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555, PREDICTED, 1'b0, STATUS_OK}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the rule store
    logic              rule_valid [RULE_SLOTS];
    logic [KEY_W-1:0]  rule_key   [RULE_SLOTS];
    logic [PERM_W-1:0] rule_mask  [RULE_SLOTS];

    t_access_req request_q [$];
    t_result     verdict_q [$];
    t_access_req live_req;
    int          fail_count;
    int          idle_cycles;

    access_rule_table_top #(
        .RULE_SLOTS (RULE_SLOTS),
        .ID_BITS    (ID_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Store a rule in the lowest free slot, or find the first matching rule
    function automatic t_result decide_access(t_access_req req);
        t_result          res;
        logic [KEY_W-1:0] key;
        bit               found;
        res.granted = 1'b0;
        res.status  = STATUS_OK;
        found       = 1'b0;
        key = {req.cls[ID_BITS-1:0], req.tgt[ID_BITS-1:0], req.src[ID_BITS-1:0]};
        if (req.mode == MODE_ADD) begin
            res.status = STATUS_FULL;
            for (int i = 0; i < RULE_SLOTS && !found; i++) begin
                if (!rule_valid[i]) begin
                    rule_valid[i] = 1'b1;
                    rule_key[i]   = key;
                    rule_mask[i]  = req.perm;
                    res.status    = STATUS_OK;
                    found         = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < RULE_SLOTS && !found; i++) begin
                if (rule_valid[i] && rule_key[i] == key) begin
                    res.granted = |(rule_mask[i] & req.perm);
                    found       = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Favor empty, full and one-hot masks beside plain random ones
    function automatic logic [PERM_W-1:0] random_permission();
        logic [PERM_W-1:0] mask;
        case ($urandom_range(9))
            0:       mask = '0;
            1:       mask = '1;
            2, 3:    mask = 32'h1 << $urandom_range(31);
            default: mask = $urandom();
        endcase
        return mask;
    endfunction

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hold reset for the opening cycles and empty the shadow store
    initial begin
        i_rst_n = 1'b0;
        for (int i = 0; i < RULE_SLOTS; i++) begin
            rule_valid[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Build the request list, drive it in bursts, then wait for the last results
    initial begin
        t_access_req           req;
        logic [3*FIELD_ID_W-1:0] key;
        logic [3*FIELD_ID_W-1:0] added_keys [$];
        int                    pick;
        int                    burst_left;
        int                    gap;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        fail_count    = 0;
        live_req      = '0;
        burst_left    = 0;

        for (int n = 0; n < DIRECTED_N; n++) begin
            request_q.push_back(DIRECTED_ROWS[n]);
        end

        // Mostly adds and checks against known rules, some near misses and noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            req       = '0;
            req.typed = PREDICTED;
            req.perm  = random_permission();
            pick      = $urandom_range(99);
            if ($urandom_range(99) < 22) begin
                req.mode = MODE_ADD;
                if (added_keys.size() > 0 && pick < 25) begin
                    key = added_keys[$urandom_range(added_keys.size() - 1)];
                end else begin
                    key = {16'($urandom()), 32'($urandom())};
                end
                added_keys.push_back(key);
            end else begin
                req.mode = MODE_CHECK;
                if (added_keys.size() > 0 && pick < 60) begin
                    key = added_keys[$urandom_range(added_keys.size() - 1)];
                end else if (added_keys.size() > 0 && pick < 80) begin
                    key = added_keys[$urandom_range(added_keys.size() - 1)]
                          ^ (48'h1 << $urandom_range(47));
                end else begin
                    key = {16'($urandom()), 32'($urandom())};
                end
            end
            {req.cls, req.tgt, req.src} = key;
            request_q.push_back(req);
        end

        wait (i_rst_n === 1'b1);
        while (request_q.size() > 0) begin
            req = request_q.pop_front();
            @(negedge i_clk);
            // Open a new burst after a random gap
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            live_req      = req;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {req.perm, req.cls, req.tgt, req.src};
            s_axis_tuser  <= req.mode;
            do @(posedge i_clk); while (!s_axis_tready);
            burst_left--;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray output
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("access_rule_table_top test passed");
        end else begin
            $display("access_rule_table_top test failed");
        end
        $finish;
    end

    // Stall the result side in segments of random length
    initial begin
        int   run;
        logic level;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    level = 1'b1;
                    run   = $urandom_range(1, 40);
                end
                9: begin
                    level = 1'b1;
                    run   = 200;
                end
                default: begin
                    level = 1'b0;
                    run   = $urandom_range(1, 15);
                end
            endcase
            @(negedge i_clk);
            m_axis_tready <= level;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    // Check each result transaction, then record the expectation of each request
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[1:0]);
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %0h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.granted !== want.granted) begin
                        $display("%0t: granted mismatch, expected %0b, actual %0b",
                                 $time, want.granted, got.granted);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:2] !== '0) begin
                        $display("%0t: padding mismatch, expected 0, actual %0h",
                                 $time, m_axis_tdata[OUT_DATA_W-1:2]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = decide_access(live_req);
                if (live_req.typed) begin
                    want.granted = live_req.exp_granted;
                    want.status  = live_req.exp_status;
                end
                verdict_q.push_back(want);
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: timeout after %0d idle cycles", $time, IDLE_LIMIT);
                $display("access_rule_table_top test failed");
                $finish;
            end
        end
    end

endmodule
